// ===== hw/rtl/rci_pkg.sv =====
// Shared types and constants for the ray versus finite cylinder intersection unit.
package rci_pkg;

  // Fixed-point format: coordinates are signed Q(32-F).F; distances, radius squared and height are unsigned Q(31-F).F.
  localparam int unsigned FracBits = 16;
  localparam int unsigned CoordW   = 32;
  localparam int unsigned DistW    = 31;
  localparam int unsigned NormW    = 16;
  localparam int unsigned ProdW    = 2 * CoordW;
  localparam int unsigned HalfW    = ProdW / 2;
  localparam int unsigned WideW    = 2 * ProdW;
  localparam int unsigned RootW    = ProdW;
  localparam int unsigned RemW     = RootW + 3;
  localparam int unsigned NumW     = ProdW + 1;
  localparam int unsigned DivW     = ProdW + DistW + FracBits + 1;
  localparam int unsigned SqrtLat  = RootW;
  localparam int unsigned DivLat   = DistW + 1;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgRadiusSq   = 2'd0,
    CfgHeight     = 2'd1,
    CfgMinDirNorm = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [DistW-1:0] radius_squared;
    logic [DistW-1:0] height;
    logic [NormW-1:0] min_dir_norm;
  } cfg_t;

  typedef struct packed {
    logic signed [CoordW-1:0] dir_x;
    logic signed [CoordW-1:0] dir_y;
    logic signed [CoordW-1:0] dir_z;
    logic signed [CoordW-1:0] org_x;
    logic signed [CoordW-1:0] org_y;
    logic signed [CoordW-1:0] org_z;
    logic        [DistW-1:0]  best_distance;
  } ray_in_t;

  typedef struct packed {
    logic             hit;
    logic             from_inside;
    logic [DistW-1:0] distance;
  } ray_out_t;

  // Fields that ride along unchanged until the height test.
  typedef struct packed {
    logic signed [CoordW-1:0] dir_y;
    logic signed [CoordW-1:0] org_y;
    logic        [DistW-1:0]  best;
  } pass_t;

  // Sideband from the discriminant front end through the square root.
  typedef struct packed {
    logic             reject;
    logic             dzero;
    logic             mpos;
    logic [ProdW-1:0] mh;
    logic [ProdW-1:0] a;
    pass_t            pass;
  } ray_side_t;

  // Sideband from the root selection stage through the dividers.
  typedef struct packed {
    logic  reject;
    logic  near_en;
    logic  far_en;
    pass_t pass;
  } root_side_t;

endpackage

// ===== hw/rtl/rci_front.sv =====
// Front end: products, quadratic coefficients and the quarter discriminant, five stages.
module rci_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          in_valid_i,
  input  rci_pkg::ray_in_t              in_beat_i,
  input  rci_pkg::cfg_t                 cfg_i,
  output logic                          out_valid_o,
  output rci_pkg::ray_side_t            side_o,
  output logic [rci_pkg::WideW-1:0]     disc_o
);

  localparam int unsigned PW = rci_pkg::ProdW;
  localparam int unsigned HW = rci_pkg::HalfW;
  localparam int unsigned WW = rci_pkg::WideW;
  localparam int unsigned F  = rci_pkg::FracBits;

  // Stage 1: the six 32 by 32 products.
  logic signed [PW-1:0] sdx, sdz, sox, soz, pxo_d, pzo_d;
  logic                 v1_q;
  logic [PW-2:0]        sq_dx_q, sq_dz_q, sq_ox_q, sq_oz_q;
  logic signed [PW-1:0] pxo_q, pzo_q;
  rci_pkg::pass_t       pass1_q;

  assign sdx   = in_beat_i.dir_x * in_beat_i.dir_x;
  assign sdz   = in_beat_i.dir_z * in_beat_i.dir_z;
  assign sox   = in_beat_i.org_x * in_beat_i.org_x;
  assign soz   = in_beat_i.org_z * in_beat_i.org_z;
  assign pxo_d = in_beat_i.dir_x * in_beat_i.org_x;
  assign pzo_d = in_beat_i.dir_z * in_beat_i.org_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_dx_q       <= sdx[PW-2:0];
      sq_dz_q       <= sdz[PW-2:0];
      sq_ox_q       <= sox[PW-2:0];
      sq_oz_q       <= soz[PW-2:0];
      pxo_q         <= pxo_d;
      pzo_q         <= pzo_d;
      pass1_q.dir_y <= in_beat_i.dir_y;
      pass1_q.org_y <= in_beat_i.org_y;
      pass1_q.best  <= in_beat_i.best_distance;
    end
  end

  // Stage 2: a, the magnitude and sign of -h, and |c|.
  logic [PW-1:0] a_d, min_a, m1, m2, mh_d, cpos, rq, cdiff_d;
  logic          hneg, mpos_d, rej2_d, cge_d;
  logic          v2_q, mpos2_q, rej2_q, cge2_q;
  logic [PW-1:0] a2_q, mh2_q, cdiff2_q;
  rci_pkg::pass_t pass2_q;

  always_comb begin
    a_d    = PW'(sq_dx_q) + PW'(sq_dz_q);
    min_a  = PW'({cfg_i.min_dir_norm, {F{1'b0}}});
    rej2_d = (a_d == '0) || (a_d < min_a);
    m1     = pxo_q[PW-1] ? PW'(-pxo_q) : PW'(pxo_q);
    m2     = pzo_q[PW-1] ? PW'(-pzo_q) : PW'(pzo_q);
    if (pxo_q[PW-1] == pzo_q[PW-1]) begin
      mh_d = m1 + m2;
      hneg = pxo_q[PW-1];
    end else if (m1 >= m2) begin
      mh_d = m1 - m2;
      hneg = pxo_q[PW-1];
    end else begin
      mh_d = m2 - m1;
      hneg = pzo_q[PW-1];
    end
    mpos_d  = hneg || (mh_d == '0);
    cpos    = PW'(sq_ox_q) + PW'(sq_oz_q);
    rq      = PW'({cfg_i.radius_squared, {F{1'b0}}});
    cge_d   = cpos >= rq;
    cdiff_d = cge_d ? (cpos - rq) : (rq - cpos);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a2_q     <= a_d;
      mh2_q    <= mh_d;
      mpos2_q  <= mpos_d;
      rej2_q   <= rej2_d;
      cge2_q   <= cge_d;
      cdiff2_q <= cdiff_d;
      pass2_q  <= pass1_q;
    end
  end

  // Stage 3: partial products of h*h and a*|c|.
  logic          v3_q, mpos3_q, rej3_q, cge3_q;
  logic [PW-1:0] a3_q, mh3_q;
  logic [PW-1:0] hh00_q, hh01_q, hh10_q, hh11_q, ac00_q, ac01_q, ac10_q, ac11_q;
  rci_pkg::pass_t pass3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh00_q  <= mh2_q[HW-1:0]  * mh2_q[HW-1:0];
      hh01_q  <= mh2_q[HW-1:0]  * mh2_q[PW-1:HW];
      hh10_q  <= mh2_q[PW-1:HW] * mh2_q[HW-1:0];
      hh11_q  <= mh2_q[PW-1:HW] * mh2_q[PW-1:HW];
      ac00_q  <= a2_q[HW-1:0]   * cdiff2_q[HW-1:0];
      ac01_q  <= a2_q[HW-1:0]   * cdiff2_q[PW-1:HW];
      ac10_q  <= a2_q[PW-1:HW]  * cdiff2_q[HW-1:0];
      ac11_q  <= a2_q[PW-1:HW]  * cdiff2_q[PW-1:HW];
      a3_q    <= a2_q;
      mh3_q   <= mh2_q;
      mpos3_q <= mpos2_q;
      rej3_q  <= rej2_q;
      cge3_q  <= cge2_q;
      pass3_q <= pass2_q;
    end
  end

  // Stage 4: sum the partial products into full-width h*h and a*|c|.
  logic [WW-1:0] h2_d, ac_d, h2_q, ac_q;
  logic          v4_q, mpos4_q, rej4_q, cge4_q;
  logic [PW-1:0] a4_q, mh4_q;
  rci_pkg::pass_t pass4_q;

  assign h2_d = WW'(hh00_q) + ((WW'(hh01_q) + WW'(hh10_q)) << HW) + (WW'(hh11_q) << PW);
  assign ac_d = WW'(ac00_q) + ((WW'(ac01_q) + WW'(ac10_q)) << HW) + (WW'(ac11_q) << PW);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h2_q    <= h2_d;
      ac_q    <= ac_d;
      a4_q    <= a3_q;
      mh4_q   <= mh3_q;
      mpos4_q <= mpos3_q;
      rej4_q  <= rej3_q;
      cge4_q  <= cge3_q;
      pass4_q <= pass3_q;
    end
  end

  // Stage 5: quarter discriminant; a negative one rejects the ray.
  logic [WW-1:0]      disc_d, disc_q;
  logic               neg_d, v5_q;
  rci_pkg::ray_side_t side_d, side_q;

  always_comb begin
    neg_d  = cge4_q && (h2_q < ac_q);
    disc_d = cge4_q ? (h2_q - ac_q) : (h2_q + ac_q);
    side_d.reject = rej4_q || neg_d;
    side_d.dzero  = (disc_d == '0);
    side_d.mpos   = mpos4_q;
    side_d.mh     = mh4_q;
    side_d.a      = a4_q;
    side_d.pass   = pass4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en_i) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      disc_q <= disc_d;
      side_q <= side_d;
    end
  end

  assign out_valid_o = v5_q;
  assign side_o      = side_q;
  assign disc_o      = disc_q;

endmodule

// ===== hw/rtl/rci_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module rci_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          in_valid_i,
  input  rci_pkg::ray_side_t            in_side_i,
  input  logic [rci_pkg::WideW-1:0]     disc_i,
  output logic                          out_valid_o,
  output rci_pkg::ray_side_t            out_side_o,
  output logic [rci_pkg::RootW-1:0]     root_o
);

  localparam int unsigned N  = rci_pkg::SqrtLat;
  localparam int unsigned RW = rci_pkg::RemW;
  localparam int unsigned SW = rci_pkg::RootW;
  localparam int unsigned WW = rci_pkg::WideW;

  logic               v_in   [N];
  logic [RW-1:0]      rem_in [N];
  logic [SW-1:0]      root_in[N];
  logic [WW-1:0]      dsh_in [N];
  rci_pkg::ray_side_t side_in[N];

  logic               v_q    [N];
  logic [RW-1:0]      rem_q  [N];
  logic [SW-1:0]      root_q [N];
  logic [WW-1:0]      dsh_q  [N];
  rci_pkg::ray_side_t side_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [RW-1:0] remc;
    logic [RW-1:0] trial;
    logic          take;

    // Stage input: the first stage starts from an empty remainder.
    if (k == 0) begin : g_first
      assign v_in[k]    = in_valid_i;
      assign rem_in[k]  = '0;
      assign root_in[k] = '0;
      assign dsh_in[k]  = disc_i;
      assign side_in[k] = in_side_i;
    end else begin : g_next
      assign v_in[k]    = v_q[k-1];
      assign rem_in[k]  = rem_q[k-1];
      assign root_in[k] = root_q[k-1];
      assign dsh_in[k]  = dsh_q[k-1];
      assign side_in[k] = side_q[k-1];
    end

    // Bring down two radicand bits and try to set the next root bit.
    assign remc  = {rem_in[k][RW-3:0], dsh_in[k][WW-1 -: 2]};
    assign trial = RW'({root_in[k], 2'b01});
    assign take  = remc >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? (remc - trial) : remc;
        root_q[k] <= {root_in[k][SW-2:0], take};
        dsh_q[k]  <= {dsh_in[k][WW-3:0], 2'b00};
        side_q[k] <= side_in[k];
      end
    end
  end

  assign out_valid_o = v_q[N-1];
  assign out_side_o  = side_q[N-1];
  assign root_o      = root_q[N-1];

endmodule

// ===== hw/rtl/rci_div.sv =====
// Pipelined restoring divider for root distances, saturating at the largest distance.
module rci_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [rci_pkg::NumW-1:0]      num_i,
  input  logic [rci_pkg::ProdW-1:0]     den_i,
  output logic [rci_pkg::DistW-1:0]     quo_o
);

  localparam int unsigned N  = rci_pkg::DivLat;
  localparam int unsigned DW = rci_pkg::DivW;
  localparam int unsigned QW = rci_pkg::DistW;
  localparam int unsigned PW = rci_pkg::ProdW;
  localparam int unsigned F  = rci_pkg::FracBits;

  logic [DW-1:0] rem_q[N];
  logic [QW-1:0] quo_q[N];
  logic [PW-1:0] den_q[N];
  logic          sat_q[N];

  // First stage: scale the numerator and check for saturation.
  logic [DW-1:0] num_w, lim_w;
  logic          sat_d;

  assign num_w = DW'({num_i, {F{1'b0}}});
  assign lim_w = DW'({den_i, {QW{1'b0}}});
  assign sat_d = num_w >= lim_w;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_w;
      quo_q[0] <= sat_d ? {QW{1'b1}} : '0;
      den_q[0] <= den_i;
      sat_q[0] <= sat_d;
    end
  end

  // Later stages: one quotient bit each, most significant first.
  for (genvar j = 1; j < N; j++) begin : g_stage
    localparam int unsigned B = QW - j;
    logic [DW-1:0] sub;
    logic          take;

    assign sub  = DW'(den_q[j-1]) << B;
    assign take = !sat_q[j-1] && (rem_q[j-1] >= sub);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= take ? (rem_q[j-1] - sub) : rem_q[j-1];
        quo_q[j] <= quo_q[j-1] | (QW'(take) << B);
        den_q[j] <= den_q[j-1];
        sat_q[j] <= sat_q[j-1];
      end
    end
  end

  assign quo_o = quo_q[N-1];

endmodule

// ===== hw/rtl/rci_back.sv =====
// Back end: height tests for both roots and final selection into the output register.
module rci_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          in_valid_i,
  input  rci_pkg::root_side_t           in_side_i,
  input  logic [rci_pkg::DistW-1:0]     near_q_i,
  input  logic [rci_pkg::DistW-1:0]     far_q_i,
  input  rci_pkg::cfg_t                 cfg_i,
  output logic                          out_valid_o,
  output rci_pkg::ray_out_t             out_beat_o
);

  localparam int unsigned PW = rci_pkg::ProdW;
  localparam int unsigned F  = rci_pkg::FracBits;

  // Stage 1: distance times the y direction for both roots.
  logic signed [PW-1:0] m1_d, m2_d, m1_q, m2_q;
  logic                 v1_q;
  logic [rci_pkg::DistW-1:0] q1_q, q2_q;
  rci_pkg::root_side_t  side1_q;

  assign m1_d = $signed({1'b0, near_q_i}) * in_side_i.pass.dir_y;
  assign m2_d = $signed({1'b0, far_q_i}) * in_side_i.pass.dir_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q    <= m1_d;
      m2_q    <= m2_d;
      q1_q    <= near_q_i;
      q2_q    <= far_q_i;
      side1_q <= in_side_i;
    end
  end

  // Stage 2: hit point within the height range, then pick the nearer valid root.
  logic signed [PW-1:0] oy_w, y1, y2;
  logic [PW-1:0]        hmax;
  logic                 ok1, ok2, near_lt, far_lt;
  rci_pkg::ray_out_t    res_d, res_q;
  logic                 v2_q;

  always_comb begin
    oy_w    = PW'(side1_q.pass.org_y) <<< F;
    y1      = m1_q + oy_w;
    y2      = m2_q + oy_w;
    hmax    = PW'({cfg_i.height, {F{1'b0}}});
    ok1     = !y1[PW-1] && ($unsigned(y1) <= hmax);
    ok2     = !y2[PW-1] && ($unsigned(y2) <= hmax);
    near_lt = q1_q < side1_q.pass.best;
    far_lt  = q2_q < side1_q.pass.best;
    res_d.hit         = 1'b0;
    res_d.from_inside = 1'b0;
    res_d.distance    = side1_q.pass.best;
    if (side1_q.reject) begin
      res_d.hit = 1'b0;
    end else if (side1_q.near_en && !near_lt) begin
      res_d.hit = 1'b0;
    end else if (side1_q.near_en && ok1) begin
      res_d.hit      = 1'b1;
      res_d.distance = q1_q;
    end else if (side1_q.far_en && far_lt && ok2) begin
      res_d.hit         = 1'b1;
      res_d.from_inside = 1'b1;
      res_d.distance    = q2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = v2_q;
  assign out_beat_o  = res_q;

endmodule

// ===== hw/rtl/ray_cylinder_intersect_unit.sv =====
// Top level of the ray versus finite cylinder side-wall intersection pipeline.
// The unit takes one ray per clock cycle and returns one result beat per ray, in order,
// through five front-end stages, 64 square-root stages (one root bit each), one root
// selection stage, 32 divider stages (a saturation check, then one quotient bit each)
// and two height test stages, the last of which is the output register. While a result
// sits in the output register and is stalled, the whole pipeline holds and the input is
// stalled too. Configuration writes are always taken and reach rays in flight that have
// not yet passed the stage that reads the register, so write them only while the unit is empty.
module ray_cylinder_intersect_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  rci_pkg::ray_in_t                in_beat_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output rci_pkg::ray_out_t               out_beat_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rci_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [rci_pkg::CfgDataW-1:0]    cfg_data_i
);

  localparam int unsigned PW = rci_pkg::ProdW;
  localparam int unsigned NW = rci_pkg::NumW;
  localparam int unsigned N  = rci_pkg::DivLat;

  // Pipeline advance: everything moves unless a finished beat is stalled.
  logic en;
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  // Configuration registers.
  rci_pkg::cfg_t cfg_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radius_squared <= rci_pkg::DistW'(1) << rci_pkg::FracBits;
      cfg_q.height         <= rci_pkg::DistW'(1) << rci_pkg::FracBits;
      cfg_q.min_dir_norm   <= rci_pkg::NormW'(1);
    end else if (cfg_valid_i) begin
      case (rci_pkg::cfg_idx_e'(cfg_index_i))
        rci_pkg::CfgRadiusSq:   cfg_q.radius_squared <= cfg_data_i[rci_pkg::DistW-1:0];
        rci_pkg::CfgHeight:     cfg_q.height         <= cfg_data_i[rci_pkg::DistW-1:0];
        rci_pkg::CfgMinDirNorm: cfg_q.min_dir_norm   <= cfg_data_i[rci_pkg::NormW-1:0];
        default: ;
      endcase
    end
  end

  // Discriminant front end.
  logic                          fr_valid;
  rci_pkg::ray_side_t            fr_side;
  logic [rci_pkg::WideW-1:0]     fr_disc;

  rci_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (in_valid_i),
    .in_beat_i   (in_beat_i),
    .cfg_i       (cfg_q),
    .out_valid_o (fr_valid),
    .side_o      (fr_side),
    .disc_o      (fr_disc)
  );

  // Square root of the discriminant.
  logic                          sq_valid;
  rci_pkg::ray_side_t            sq_side;
  logic [rci_pkg::RootW-1:0]     sq_root;

  rci_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (fr_valid),
    .in_side_i   (fr_side),
    .disc_i      (fr_disc),
    .out_valid_o (sq_valid),
    .out_side_o  (sq_side),
    .root_o      (sq_root)
  );

  // Root selection: numerators of the near and far roots, or the tangent root.
  logic [NW-1:0]       n1_d, n2_d, n1_q, n2_q;
  logic [PW-1:0]       a_q;
  rci_pkg::root_side_t rs_d, rs_q;
  logic                rs_v_q;

  always_comb begin
    rs_d.pass    = sq_side.pass;
    rs_d.reject  = sq_side.reject;
    rs_d.near_en = 1'b0;
    rs_d.far_en  = 1'b0;
    n1_d         = NW'(sq_side.mh) - NW'(sq_root);
    n2_d         = NW'(sq_side.mh) + NW'(sq_root);
    if (sq_side.dzero) begin
      n1_d         = NW'(sq_side.mh);
      rs_d.near_en = sq_side.mpos && (sq_side.mh != '0);
    end else begin
      rs_d.near_en = sq_side.mpos && (sq_side.mh > sq_root);
      if (sq_side.mpos) begin
        rs_d.far_en = 1'b1;
      end else if (sq_root > sq_side.mh) begin
        n2_d        = NW'(sq_root) - NW'(sq_side.mh);
        rs_d.far_en = 1'b1;
      end else begin
        rs_d.reject = 1'b1;
      end
      if (rs_d.far_en && (n2_d == '0)) begin
        rs_d.reject = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_v_q <= 1'b0;
    end else if (en) begin
      rs_v_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n1_q <= n1_d;
      n2_q <= n2_d;
      a_q  <= sq_side.a;
      rs_q <= rs_d;
    end
  end

  // Root distances, both roots side by side.
  logic [rci_pkg::DistW-1:0] q_near, q_far;

  rci_div u_div_near (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (n1_q),
    .den_i (a_q),
    .quo_o (q_near)
  );

  rci_div u_div_far (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (n2_q),
    .den_i (a_q),
    .quo_o (q_far)
  );

  // Sideband delay line matching the divider depth.
  logic                dl_v_q   [N];
  rci_pkg::root_side_t dl_side_q[N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dl_v_q[0] <= 1'b0;
    end else if (en) begin
      dl_v_q[0] <= rs_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dl_side_q[0] <= rs_q;
    end
  end

  for (genvar j = 1; j < N; j++) begin : g_delay
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dl_v_q[j] <= 1'b0;
      end else if (en) begin
        dl_v_q[j] <= dl_v_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dl_side_q[j] <= dl_side_q[j-1];
      end
    end
  end

  // Height tests and output register.
  rci_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (dl_v_q[N-1]),
    .in_side_i   (dl_side_q[N-1]),
    .near_q_i    (q_near),
    .far_q_i     (q_far),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid_o),
    .out_beat_o  (out_beat_o)
  );

endmodule

// ===== hw/rtl/rci_checker.sv =====
// Port-level checks for the intersection unit and their binding to the top level.
module rci_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input rci_pkg::ray_out_t               out_beat_o,
  input logic                            cfg_ready_o
);

  // The input is held back only while a finished beat waits at the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled output beat");

  // A stalled output beat stays and does not change.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_beat_o)))
    else $error("stalled output beat changed");

  // A miss never reports leaving from inside.
  a_miss_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_beat_o.hit) |-> !out_beat_o.from_inside)
    else $error("miss flagged as from inside");

  // A saturated distance can never beat the best distance so far.
  a_hit_not_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_beat_o.hit) |-> (out_beat_o.distance != '1))
    else $error("hit reported at saturated distance");

  // Configuration writes are always taken.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind ray_cylinder_intersect_unit rci_checker u_rci_checker (.*);
